// ----- rtl/bbe_pkg.sv -----
// shared definitions for the b-spline span and basis evaluator
// default sizes and the sequencer state type; no dependencies
`default_nettype none

package bbe_pkg;

   localparam int unsigned DEF_MAX_KNOTS  = 64;
   localparam int unsigned DEF_MAX_DEGREE = 7;
   localparam int unsigned DEF_FRAC_BITS  = 16;

   // request kinds carried on tuser
   localparam logic KIND_KNOT_WRITE = 1'b0;
   localparam logic KIND_EVALUATE   = 1'b1;

   // register indexes on the csr channel
   localparam logic CSR_DEGREE     = 1'b0;
   localparam logic CSR_KNOT_COUNT = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LIM,
      S_LIMW,
      S_K0W,
      S_MID,
      S_MID1,
      S_CHK,
      S_JL,
      S_JR,
      S_JRW,
      S_MUL,
      S_DIV,
      S_QDONE,
      S_LOAD,
      S_EMIT
   } bbe_state_type;

endpackage

`default_nettype wire

// ----- rtl/bspline_basis_evaluator_core.sv -----
// b-spline knot table, binary span search and cox-de boor recurrence; uses bbe_pkg
// knot writes are taken in idle; an evaluation runs the span search, then D = p*(p+1)/2
//   recurrence steps on the shared restoring divider before the first result beat
// throughput: one request at a time, ready again once the last result beat is taken;
//   p+1 result beats, or a single out-of-range beat
// reset: synchronous active high; degree 3, knot_count 8; knot table undefined until written
`default_nettype none

module bspline_basis_evaluator_core #(
   parameter int unsigned MAX_KNOTS  = bbe_pkg::DEF_MAX_KNOTS,
   parameter int unsigned MAX_DEGREE = bbe_pkg::DEF_MAX_DEGREE,
   parameter int unsigned FRAC_BITS  = bbe_pkg::DEF_FRAC_BITS
) (
   input  wire logic clock,
   input  wire logic reset,
   // request channel
   input  wire logic req_tvalid,
   output logic      req_tready,
   // tdata, lowest bit up: knot_index, knot_value, param_u, zero pad
   input  wire logic [((($clog2(MAX_KNOTS) + 2*(FRAC_BITS+1)) + 7) / 8) * 8 - 1:0] req_tdata,
   // tuser: kind
   input  wire logic req_tuser,
   // response channel
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // tdata, lowest bit up: span_index, basis_offset, basis_value, zero pad
   output logic [((($clog2(MAX_KNOTS) + $clog2(MAX_DEGREE+1) + FRAC_BITS + 1) + 7) / 8) * 8 - 1:0]
                     rsp_tdata,
   // tuser: out_of_range
   output logic      rsp_tuser,
   output logic      rsp_tlast,
   // configuration write channel
   input  wire logic csr_valid,
   output logic      csr_ready,
   input  wire logic csr_index,
   input  wire logic [$clog2(MAX_KNOTS+1)-1:0] csr_data
);

   import bbe_pkg::*;

   localparam int unsigned VW    = FRAC_BITS + 1;            // value width
   localparam int unsigned AW    = $clog2(MAX_KNOTS);        // table address
   localparam int unsigned CW    = $clog2(MAX_KNOTS + 1);    // knot count
   localparam int unsigned DGW   = $clog2(MAX_DEGREE + 1);   // degree and offsets
   localparam int unsigned XW    = CW + DGW + 1;             // index arithmetic
   localparam int unsigned PW    = 2 * VW;                   // product
   localparam int unsigned CNTW  = $clog2(VW);
   localparam int unsigned RSP_W = AW + DGW + VW;
   localparam int unsigned RSP_DW = ((RSP_W + 7) / 8) * 8;
   localparam logic [VW-1:0] ONE = VW'(1) << FRAC_BITS;

   // request fields
   logic [AW-1:0] f_knot_index;
   logic [VW-1:0] f_knot_value;
   logic [VW-1:0] f_param_u;
   assign f_knot_index = req_tdata[AW-1:0];
   assign f_knot_value = req_tdata[AW+VW-1:AW];
   assign f_param_u    = req_tdata[AW+2*VW-1:AW+VW];

   // configuration
   logic [DGW-1:0] degree_ff;
   logic [CW-1:0]  kcount_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= DGW'(3);
         kcount_ff <= CW'(8);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEGREE:     degree_ff <= csr_data[DGW-1:0];
            CSR_KNOT_COUNT: kcount_ff <= csr_data;
            default:        ;
         endcase
      end
   end

   // effective degree and knot count, clamped to the table sizes
   logic [DGW-1:0] p_c;
   logic [CW-1:0]  m_c;
   logic [XW-1:0]  nu_c;
   logic           too_few_c;
   assign p_c = (degree_ff > DGW'(MAX_DEGREE)) ? DGW'(MAX_DEGREE) : degree_ff;
   assign m_c = (kcount_ff > CW'(MAX_KNOTS)) ? CW'(MAX_KNOTS) : kcount_ff;
   assign too_few_c = XW'(m_c) < ((XW'(p_c) << 1) + XW'(2));
   assign nu_c = XW'(m_c) - XW'(p_c) - XW'(2);

   // knot table, one write and one registered read port
   logic [VW-1:0] knot_mem [MAX_KNOTS];
   logic [VW-1:0] rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         knot_mem[f_knot_index] <= f_knot_value;
      end
      rd_data_ff <= knot_mem[rd_addr];
   end

   // sequencer state and datapath registers
   bbe_state_type state_ff, state_in;
   logic [VW-1:0]  u_ff, u_in;
   logic [XW-1:0]  span_ff, span_in, low_ff, low_in, high_ff, high_in, mid_ff, mid_in;
   logic [VW-1:0]  umid_ff, umid_in;
   logic [DGW-1:0] j_ff, j_in, r_ff, r_in, oj_ff, oj_in;
   logic           sel_ff, sel_in;
   logic [VW-1:0]  a_ff, a_in, saved_ff, saved_in;
   logic [VW-1:0]  nb_ff [MAX_DEGREE+1];
   logic [VW-1:0]  nb_in [MAX_DEGREE+1];
   logic [VW-1:0]  lft_ff [MAX_DEGREE+1];
   logic [VW-1:0]  lft_in [MAX_DEGREE+1];
   logic [VW-1:0]  rgt_ff [MAX_DEGREE+1];
   logic [VW-1:0]  rgt_in [MAX_DEGREE+1];
   logic [PW-1:0]  prod_ff, prod_in;
   logic [VW:0]    rem_ff, rem_in;
   logic [VW-1:0]  quo_ff, quo_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;

   // response output registers
   logic           rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]  rsp_span_ff, rsp_span_in;
   logic [DGW-1:0] rsp_ofs_ff, rsp_ofs_in;
   logic [VW-1:0]  rsp_val_ff, rsp_val_in;
   logic           rsp_oor_ff, rsp_oor_in;
   logic           rsp_last_ff, rsp_last_in;

   // shared unit operands: recurrence terms, one multiplier, one divider step
   logic [VW-1:0]  rr_c, ll_c;
   logic [VW:0]    den_c;
   logic [PW-1:0]  prod_c;
   logic [VW+1:0]  rem2_c;
   logic [VW:0]    sum_c;
   logic [XW:0]    mid_sum_c;
   logic [XW-1:0]  nlow_c, nhigh_c;
   logic           start_rec, go_oor, advance;
   logic [VW-1:0]  saved_new;

   assign rr_c   = rgt_ff[r_ff + DGW'(1)];
   assign ll_c   = lft_ff[j_ff - r_ff];
   assign den_c  = {1'b0, rr_c} + {1'b0, ll_c};
   assign prod_c = PW'(nb_ff[r_ff]) * PW'(sel_ff ? ll_c : rr_c);
   assign rem2_c = {rem_ff, prod_ff[VW-1]};

   always_comb begin
      state_in = state_ff;
      u_in = u_ff;
      span_in = span_ff;
      low_in = low_ff;
      high_in = high_ff;
      mid_in = mid_ff;
      umid_in = umid_ff;
      j_in = j_ff;
      r_in = r_ff;
      oj_in = oj_ff;
      sel_in = sel_ff;
      a_in = a_ff;
      saved_in = saved_ff;
      nb_in = nb_ff;
      lft_in = lft_ff;
      rgt_in = rgt_ff;
      prod_in = prod_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_span_in = rsp_span_ff;
      rsp_ofs_in = rsp_ofs_ff;
      rsp_val_in = rsp_val_ff;
      rsp_oor_in = rsp_oor_ff;
      rsp_last_in = rsp_last_ff;
      req_tready = 1'b0;
      wr_en = 1'b0;
      rd_addr = '0;
      start_rec = 1'b0;
      go_oor = 1'b0;
      advance = 1'b0;
      saved_new = saved_ff;
      sum_c = '0;
      mid_sum_c = '0;
      nlow_c = low_ff;
      nhigh_c = high_ff;

      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == KIND_KNOT_WRITE) begin
                  wr_en = ({1'b0, f_knot_index} < (AW+1)'(MAX_KNOTS));
               end else begin
                  u_in = f_param_u;
                  if (too_few_c) begin
                     go_oor = 1'b1;
                  end else begin
                     state_in = S_LIM;
                  end
               end
            end
         end
         S_LIM: begin
            rd_addr = AW'(nu_c + XW'(1));
            state_in = S_LIMW;
         end
         S_LIMW: begin
            // upper knot: u equal to it lands in the last span
            rd_addr = '0;
            if (u_ff == rd_data_ff) begin
               span_in = nu_c;
               start_rec = 1'b1;
            end else if (u_ff > rd_data_ff) begin
               go_oor = 1'b1;
            end else begin
               state_in = S_K0W;
            end
         end
         S_K0W: begin
            if (u_ff < rd_data_ff) begin
               go_oor = 1'b1;
            end else begin
               low_in = XW'(p_c);
               high_in = nu_c + XW'(1);
               mid_sum_c = (XW+1)'(p_c) + (XW+1)'(nu_c) + (XW+1)'(1);
               mid_in = mid_sum_c[XW:1];
               state_in = S_MID;
            end
         end
         S_MID: begin
            rd_addr = AW'(mid_ff);
            state_in = S_MID1;
         end
         S_MID1: begin
            umid_in = rd_data_ff;
            rd_addr = AW'(mid_ff + XW'(1));
            state_in = S_CHK;
         end
         S_CHK: begin
            // rd_data_ff holds the knot right above mid
            if (!(u_ff < umid_ff || u_ff >= rd_data_ff) || !((high_ff - low_ff) > XW'(1))) begin
               span_in = mid_ff;
               start_rec = 1'b1;
            end else begin
               if (u_ff < umid_ff) begin
                  nhigh_c = mid_ff;
               end else begin
                  nlow_c = mid_ff;
               end
               low_in = nlow_c;
               high_in = nhigh_c;
               mid_sum_c = (XW+1)'(nlow_c) + (XW+1)'(nhigh_c);
               mid_in = mid_sum_c[XW:1];
               state_in = S_MID;
            end
         end
         S_JL: begin
            rd_addr = AW'(span_ff + XW'(1) - XW'(j_ff));
            state_in = S_JR;
         end
         S_JR: begin
            lft_in[j_ff] = (u_ff > rd_data_ff) ? (u_ff - rd_data_ff) : '0;
            rd_addr = AW'(span_ff + XW'(j_ff));
            state_in = S_JRW;
         end
         S_JRW: begin
            rgt_in[j_ff] = (rd_data_ff > u_ff) ? (rd_data_ff - u_ff) : '0;
            r_in = '0;
            saved_in = '0;
            sel_in = 1'b0;
            state_in = S_MUL;
         end
         S_MUL: begin
            if (den_c == '0) begin
               // zero denominator: both quotients are zero
               nb_in[r_ff] = saved_ff;
               saved_new = '0;
               advance = 1'b1;
            end else begin
               prod_in = prod_c;
               rem_in = {1'b0, prod_c[PW-1:VW]};
               quo_in = '0;
               cnt_in = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // restoring division, one quotient bit a cycle
            prod_in = prod_ff << 1;
            if (rem2_c >= {1'b0, den_c}) begin
               rem_in = (VW+1)'(rem2_c - {1'b0, den_c});
               quo_in = {quo_ff[VW-2:0], 1'b1};
            end else begin
               rem_in = rem2_c[VW:0];
               quo_in = {quo_ff[VW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNTW'(1);
            if (cnt_ff == CNTW'(VW - 1)) begin
               state_in = S_QDONE;
            end
         end
         S_QDONE: begin
            if (!sel_ff) begin
               a_in = quo_ff;
               sel_in = 1'b1;
               state_in = S_MUL;
            end else begin
               sum_c = {1'b0, saved_ff} + {1'b0, a_ff};
               nb_in[r_ff] = (sum_c > {1'b0, ONE}) ? ONE : sum_c[VW-1:0];
               saved_new = (quo_ff > ONE) ? ONE : quo_ff;
               advance = 1'b1;
            end
         end
         S_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_span_in = span_ff[AW-1:0];
            rsp_ofs_in = oj_ff;
            rsp_val_in = nb_ff[oj_ff];
            rsp_oor_in = 1'b0;
            rsp_last_in = (oj_ff == p_c);
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  oj_in = oj_ff + DGW'(1);
                  state_in = S_LOAD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // one recurrence step done: next r, next row, or results
      if (advance) begin
         saved_in = saved_new;
         sel_in = 1'b0;
         if (r_ff + DGW'(1) == j_ff) begin
            nb_in[j_ff] = saved_new;
            if (j_ff == p_c) begin
               oj_in = '0;
               state_in = S_LOAD;
            end else begin
               j_in = j_ff + DGW'(1);
               state_in = S_JL;
            end
         end else begin
            r_in = r_ff + DGW'(1);
            state_in = S_MUL;
         end
      end

      // span known: seed the triangle
      if (start_rec) begin
         nb_in[0] = ONE;
         j_in = DGW'(1);
         oj_in = '0;
         state_in = (p_c == '0) ? S_LOAD : S_JL;
      end

      // single out-of-range beat
      if (go_oor) begin
         rsp_valid_in = 1'b1;
         rsp_span_in = '0;
         rsp_ofs_in = '0;
         rsp_val_in = '0;
         rsp_oor_in = 1'b1;
         rsp_last_in = 1'b1;
         state_in = S_EMIT;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      u_ff <= u_in;
      span_ff <= span_in;
      low_ff <= low_in;
      high_ff <= high_in;
      mid_ff <= mid_in;
      umid_ff <= umid_in;
      j_ff <= j_in;
      r_ff <= r_in;
      oj_ff <= oj_in;
      sel_ff <= sel_in;
      a_ff <= a_in;
      saved_ff <= saved_in;
      nb_ff <= nb_in;
      lft_ff <= lft_in;
      rgt_ff <= rgt_in;
      prod_ff <= prod_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      rsp_span_ff <= rsp_span_in;
      rsp_ofs_ff <= rsp_ofs_in;
      rsp_val_ff <= rsp_val_in;
      rsp_oor_ff <= rsp_oor_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DW'({rsp_val_ff, rsp_ofs_ff, rsp_span_ff});
   assign rsp_tuser  = rsp_oor_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ----- dv/bspline_basis_evaluator_core_tb.sv -----
// self-checking testbench for bspline_basis_evaluator_core: knot loads, span search, basis beats
// depends on rtl/bbe_pkg.sv and rtl/bspline_basis_evaluator_core.sv
// random knot vectors per csr setting, random stalls on both sides, scoreboard in a small class
`default_nettype none

module bspline_basis_evaluator_core_tb;
   import bbe_pkg::*;

   localparam int unsigned KNOTS = 64;
   localparam int unsigned ONE   = 65536;

   // one expected result beat
   typedef struct packed {
      logic [5:0]  span;
      logic [2:0]  ofs;
      logic [16:0] val;
      logic        oor;
      logic        last;
   } basis_beat_t;

   // predictor and expected-beat queue
   class basis_scoreboard;
      logic [16:0]  knots[KNOTS];
      int unsigned  degree_reg = 3;
      int unsigned  count_reg  = 8;
      basis_beat_t  pending[$];
      int unsigned  mismatches = 0;

      function void set_reg(logic idx, int unsigned val);
         if (idx == CSR_DEGREE) degree_reg = val & 7;
         else count_reg = val & 127;
      endfunction

      function longint unsigned knot(longint k);
         if (k < 0 || k >= KNOTS) return 0;
         return knots[k];
      endfunction

      function void push_oor();
         basis_beat_t b;
         b = '0;
         b.oor = 1'b1;
         b.last = 1'b1;
         pending = {pending, b};
      endfunction

      function void note_request(logic kind, logic [5:0] idx, logic [16:0] kval,
                                 logic [16:0] u);
         longint p, m, nu, lo, hi, mid, span, iter;
         longint unsigned lim, uu, saved, rr, ll, den, a, b;
         longint unsigned nb[8], lft[8], rgt[8];
         basis_beat_t bt;
         if (kind == KIND_KNOT_WRITE) begin
            knots[idx] = kval;
            return;
         end
         uu = u;
         p = (degree_reg > 7) ? 7 : degree_reg;
         m = (count_reg > KNOTS) ? KNOTS : count_reg;
         if (m < 2 * p + 2) begin
            push_oor();
            return;
         end
         nu = m - p - 2;
         lim = knot(nu + 1);
         if (uu == lim) begin
            span = nu;
         end else if (uu > lim || uu < knot(0)) begin
            push_oor();
            return;
         end else begin
            lo = p;
            hi = nu + 1;
            mid = (lo + hi) / 2;
            iter = 0;
            while ((uu < knot(mid) || uu >= knot(mid + 1)) && hi - lo > 1 && iter < KNOTS) begin
               if (uu < knot(mid)) hi = mid;
               else lo = mid;
               mid = (lo + hi) / 2;
               iter++;
            end
            span = mid;
         end
         // triangular recurrence, truncating quotients, zero denominator gives zero
         nb[0] = ONE;
         lft[0] = 0;
         rgt[0] = 0;
         for (int j = 1; j <= p; j++) begin
            saved = 0;
            lft[j] = (uu > knot(span + 1 - j)) ? uu - knot(span + 1 - j) : 0;
            rgt[j] = (knot(span + j) > uu) ? knot(span + j) - uu : 0;
            for (int r = 0; r < j; r++) begin
               rr = rgt[r + 1];
               ll = lft[j - r];
               den = rr + ll;
               a = 0;
               b = 0;
               if (den != 0) begin
                  a = (nb[r] * rr) / den;
                  b = (nb[r] * ll) / den;
               end
               nb[r] = (saved + a > ONE) ? ONE : saved + a;
               saved = (b > ONE) ? ONE : b;
            end
            nb[j] = saved;
         end
         for (int j = 0; j <= p; j++) begin
            bt.span = span[5:0];
            bt.ofs  = j[2:0];
            bt.val  = nb[j][16:0];
            bt.oor  = 1'b0;
            bt.last = (j == p);
            pending = {pending, bt};
         end
      endfunction

      function void check_beat(basis_beat_t got);
         basis_beat_t want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: span %0d ofs %0d val %0d oor %0b last %0b",
                        got.span, got.ofs, got.val, got.oor, got.last);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("beat mismatch: exp %0d/%0d/%0d/%0b/%0b got %0d/%0d/%0d/%0b/%0b",
                        want.span, want.ofs, want.val, want.oor, want.last,
                        got.span, got.ofs, got.val, got.oor, got.last);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [6:0]  csr_data;

   basis_scoreboard sb;
   logic [16:0] knot_shadow[KNOTS];  // knots as the stimulus side sees them
   int unsigned beats_seen = 0;
   bit          calm = 0;            // no idling on either side while set
   bit          held = 0;

   bspline_basis_evaluator_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      #60000000;
      $display("bspline_basis_evaluator_core_tb NOT OK");
      $finish;
   end

   // mostly short gaps, a few long ones
   function automatic int unsigned idle_len();
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // toggle stretches with no idling at all
   initial begin
      forever begin
         repeat ($urandom_range(100, 600)) @(posedge clock);
         calm = ($urandom_range(0, 3) == 0);
      end
   end

   // send one request beat, note it in the scoreboard once accepted
   task automatic send_req(logic kind, logic [5:0] idx, logic [16:0] kval, logic [16:0] u);
      int unsigned g;
      g = idle_len();
      if (g > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (g - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {u, kval, idx};
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, idx, kval, u);
      if (kind == KIND_KNOT_WRITE) knot_shadow[idx] = kval;
   endtask

   task automatic write_knot(logic [5:0] idx, logic [16:0] kval);
      send_req(KIND_KNOT_WRITE, idx, kval, 17'($urandom()));
   endtask

   task automatic evaluate(logic [16:0] u);
      send_req(KIND_EVALUATE, 6'($urandom()), 17'($urandom()), u);
   endtask

   // csr write only once the block has drained
   task automatic write_csr(logic idx, logic [6:0] val);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);  // leaves room for a trailing knot write
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // load a knot vector: clamped and ascending, or scrambled noise
   task automatic load_knots(int unsigned m, int unsigned p, bit scrambled);
      int unsigned v, lo_end, hi_start;
      v = $urandom_range(0, 3) == 0 ? $urandom_range(0, 8000) : 0;
      lo_end = p;
      hi_start = (m > p + 1) ? m - p - 1 : 0;
      for (int k = 0; k < m && k < KNOTS; k++) begin
         if (scrambled) begin
            write_knot(6'(k),
                       17'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, ONE)));
         end else begin
            if (k >= hi_start && k > lo_end) v = (ONE > v) ? ($urandom_range(0, 1) ? ONE : v) : v;
            else if (k > lo_end && $urandom_range(0, 4) != 0) v = v + $urandom_range(1, 9000);
            if (v > ONE) v = ONE;
            write_knot(6'(k), 17'(v));
         end
      end
   endtask

   // parameter pick: mostly inside the knot range, plus exact knots and outliers
   function automatic logic [16:0] pick_u(int unsigned m, int unsigned p);
      int unsigned r, top, lim, base;
      r = $urandom_range(0, 99);
      top = (m > KNOTS) ? KNOTS : m;
      lim = (top > p + 1) ? knot_shadow[top - p - 1] : 0;
      base = knot_shadow[0];
      if (r < 10 && top > 0) return knot_shadow[$urandom_range(0, top - 1)];
      if (r < 14) return 17'($urandom());
      if (r < 17) return 17'(lim);
      if (r < 19) return 17'h1FFFF;
      if (lim > base) return 17'($urandom_range(base, lim));
      return 17'($urandom_range(0, ONE));
   endfunction

   // response side: random stalls, one long hold-off to back up the request side
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (!held && beats_seen >= 60) begin
            held = 1;
            stall_left = 3000;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 2) == 0) stall_left = idle_len();
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_beat({rsp_tdata[5:0], rsp_tdata[8:6], rsp_tdata[25:9], rsp_tuser, rsp_tlast});
         beats_seen++;
      end
   end

   // main sequence
   initial begin
      int unsigned degs[10];
      int unsigned counts[10];
      int unsigned m, p, n_eval;
      bit scr;
      degs   = '{0, 1, 7, 7, 2, 5, 3, 4, 6, 1};
      counts = '{2, 4, 16, 24, 127, 11, 20, 12, 14, 0};
      sb = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = KIND_KNOT_WRITE;
      csr_valid  = 1'b0;
      csr_index  = CSR_DEGREE;
      csr_data   = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // default eight-knot vector; each phase loads every knot it uses
      for (int k = 0; k < 8; k++)
         write_knot(6'(k), k < 4 ? 17'd4096 : 17'd65536);

      // directed: default cubic with 8 knots, range edges and outliers
      evaluate(17'd0);
      evaluate(17'd4095);
      evaluate(17'd4096);
      evaluate(17'd30000);
      evaluate(17'd65535);
      evaluate(17'd65536);
      evaluate(17'h10001);
      evaluate(17'h1FFFF);
      // repeated interior knot, zero denominators along the recurrence
      write_knot(4, 17'd4096);
      evaluate(17'd4096);
      evaluate(17'd50000);
      write_knot(4, 17'd32768);
      evaluate(17'd32768);
      evaluate(17'd32767);

      // random phases over csr settings
      for (int ph = 0; ph < 10; ph++) begin
         p = degs[ph];
         m = counts[ph];
         write_csr(CSR_DEGREE, 7'(p));
         write_csr(CSR_KNOT_COUNT, 7'(m));
         scr = ($urandom_range(0, 4) == 0);
         load_knots(m, p, scr);
         n_eval = (p >= 6) ? 6 : 8;
         for (int i = 0; i < n_eval; i++) begin
            if ($urandom_range(0, 19) == 0)
               write_knot(6'($urandom_range(0, (m > KNOTS ? KNOTS : (m > 0 ? m : 1)) - 1)),
                          17'($urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(0, ONE)));
            evaluate(pick_u(m, p));
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("bspline_basis_evaluator_core_tb OK");
      end else begin
         $display("bspline_basis_evaluator_core_tb NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
